// File: hw/rtl/kas_pkg.sv
// Package for the key auto-repeat scanner: field widths, stick thresholds,
// register indexes and reset values. Has no dependencies.
`default_nettype none

package kas_pkg;

   // Fixed field widths of the frame and result beats.
   localparam int LEVEL_BITS = 12;
   localparam int STICK_BITS = 8;
   localparam int DIR_BITS   = 4;
   localparam int CFG_BITS   = 16;
   localparam int CSR_IDX_BITS = 2;

   // Defaults of the top-level parameters.
   localparam int NUM_KEYS_DEF   = 12;
   localparam int COUNT_BITS_DEF = 16;

   // Stick dead zone: below the low mark or above the high mark is a direction.
   localparam logic [STICK_BITS-1:0] STICK_LOW  = STICK_BITS'(64);
   localparam logic [STICK_BITS-1:0] STICK_HIGH = STICK_BITS'(191);

   // Bit positions of the direction flags.
   localparam int DIR_UP    = 0;
   localparam int DIR_DOWN  = 1;
   localparam int DIR_LEFT  = 2;
   localparam int DIR_RIGHT = 3;

   // Configuration register indexes.
   localparam logic [CSR_IDX_BITS-1:0] REG_REPEAT_DELAY  = CSR_IDX_BITS'(0);
   localparam logic [CSR_IDX_BITS-1:0] REG_REPEAT_PERIOD = CSR_IDX_BITS'(1);

   localparam logic [CFG_BITS-1:0] DELAY_RESET  = CFG_BITS'(30);
   localparam logic [CFG_BITS-1:0] PERIOD_RESET = CFG_BITS'(5);

endpackage : kas_pkg

`default_nettype wire

// File: hw/rtl/key_autorepeat_scanner_unit.sv
// Key auto-repeat scanner top level: per-key hold counters, repeat phases,
// stick direction flags. Depends on kas_pkg.
//
//   Channel | Ports                          | Direction | Handshake
//   --------+--------------------------------+-----------+----------------
//   frame   | req_button_levels, req_stick_* | in        | req_valid/stall
//   result  | rsp_press_events, held, dirs   | out       | rsp_valid/stall
//   config  | csr_index, csr_wdata           | in        | csr_write_en
//
// One frame beat is taken every cycle while req_stall is low. Its result is on
// the result ports once it has passed the input register and then the result
// register. The key counters update in a single pass when a frame moves from
// the input register to the result register. A stalled result holds; the input
// register still takes one more beat behind it. Reset is synchronous; it clears
// the valid flags and the key counters and loads the configuration reset values.
`default_nettype none

module key_autorepeat_scanner_unit
   import kas_pkg::*;
#(
   parameter int NUM_KEYS   = NUM_KEYS_DEF,
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_valid,
   output logic                     req_stall,
   input  wire [LEVEL_BITS-1:0]     req_button_levels,
   input  wire [STICK_BITS-1:0]     req_stick_x,
   input  wire [STICK_BITS-1:0]     req_stick_y,
   output logic                     rsp_valid,
   input  wire                      rsp_stall,
   output logic [LEVEL_BITS-1:0]    rsp_press_events,
   output logic [LEVEL_BITS-1:0]    rsp_held_keys,
   output logic [DIR_BITS-1:0]      rsp_stick_dirs,
   input  wire                      csr_write_en,
   input  wire [CSR_IDX_BITS-1:0]   csr_index,
   input  wire [CFG_BITS-1:0]       csr_wdata
);

   localparam int CMP_BITS = (COUNT_BITS > CFG_BITS) ? COUNT_BITS : CFG_BITS;

   logic                  in_valid_ff;
   logic [LEVEL_BITS-1:0] in_levels_ff;
   logic [STICK_BITS-1:0] in_x_ff;
   logic [STICK_BITS-1:0] in_y_ff;

   logic                  out_valid_ff;
   logic [LEVEL_BITS-1:0] out_events_ff, out_events_in;
   logic [LEVEL_BITS-1:0] out_held_ff, out_held_in;
   logic [DIR_BITS-1:0]   out_dirs_ff, out_dirs_in;

   logic [CFG_BITS-1:0]   delay_ff;
   logic [CFG_BITS-1:0]   period_ff;
   logic [CFG_BITS-1:0]   delay_eff;
   logic [CFG_BITS-1:0]   period_eff;

   logic [COUNT_BITS-1:0] hold_ff [NUM_KEYS];
   logic [COUNT_BITS-1:0] hold_in [NUM_KEYS];
   logic [CFG_BITS-1:0]   phase_ff [NUM_KEYS];
   logic [CFG_BITS-1:0]   phase_in [NUM_KEYS];
   logic [NUM_KEYS-1:0]   key_down;
   logic [NUM_KEYS-1:0]   key_event;

   logic out_free;
   logic advance;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;

   // A zero delay or period behaves as one.
   assign delay_eff  = (delay_ff == '0) ? CFG_BITS'(1) : delay_ff;
   assign period_eff = (period_ff == '0) ? CFG_BITS'(1) : period_ff;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff  <= DELAY_RESET;
         period_ff <= PERIOD_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            REG_REPEAT_DELAY:  delay_ff  <= csr_wdata;
            REG_REPEAT_PERIOD: period_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_levels_ff <= req_button_levels;
         in_x_ff      <= req_stick_x;
         in_y_ff      <= req_stick_y;
      end
   end

   // Per-key counter logic.
   for (genvar k = 0; k < NUM_KEYS; k++) begin : g_key
      logic [COUNT_BITS-1:0] now;
      logic [CFG_BITS:0]     phase_inc;
      logic                  now_reached;
      logic                  prev_reached;
      logic [CFG_BITS-1:0]   phase_step;

      if (k < LEVEL_BITS) begin : g_lvl
         assign key_down[k] = in_levels_ff[k];
      end else begin : g_nolvl
         // Keys beyond the field width never see a held level.
         assign key_down[k] = 1'b0;
      end

      always_comb begin
         now          = (hold_ff[k] == '1) ? hold_ff[k] : hold_ff[k] + COUNT_BITS'(1);
         now_reached  = CMP_BITS'(now) >= CMP_BITS'(delay_eff);
         prev_reached = CMP_BITS'(hold_ff[k]) >= CMP_BITS'(delay_eff);
         phase_inc    = {1'b0, phase_ff[k]} + (CFG_BITS+1)'(1);
         phase_step   = (phase_inc >= {1'b0, period_eff}) ? '0
                                                           : phase_inc[CFG_BITS-1:0];
         hold_in[k]   = '0;
         phase_in[k]  = '0;
         key_event[k] = 1'b0;
         if (key_down[k]) begin
            hold_in[k]   = now;
            phase_in[k]  = phase_ff[k];
            key_event[k] = (now == COUNT_BITS'(1));
            if (now_reached) begin
               // The frame that first reaches the delay restarts the phase.
               phase_in[k] = prev_reached ? phase_step : '0;
               if (phase_in[k] == '0) begin
                  key_event[k] = 1'b1;
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            hold_ff[k]  <= '0;
            phase_ff[k] <= '0;
         end else if (advance) begin
            hold_ff[k]  <= hold_in[k];
            phase_ff[k] <= phase_in[k];
         end
      end
   end

   // Fold key results onto the fixed-width result fields.
   for (genvar j = 0; j < LEVEL_BITS; j++) begin : g_out
      if (j < NUM_KEYS) begin : g_map
         assign out_events_in[j] = key_event[j];
         assign out_held_in[j]   = key_down[j];
      end else begin : g_zero
         assign out_events_in[j] = 1'b0;
         assign out_held_in[j]   = 1'b0;
      end
   end

   always_comb begin
      out_dirs_in            = '0;
      out_dirs_in[DIR_UP]    = in_y_ff < STICK_LOW;
      out_dirs_in[DIR_DOWN]  = in_y_ff > STICK_HIGH;
      out_dirs_in[DIR_LEFT]  = in_x_ff < STICK_LOW;
      out_dirs_in[DIR_RIGHT] = in_x_ff > STICK_HIGH;
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_events_ff <= out_events_in;
         out_held_ff   <= out_held_in;
         out_dirs_ff   <= out_dirs_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_press_events = out_events_ff;
   assign rsp_held_keys    = out_held_ff;
   assign rsp_stick_dirs   = out_dirs_ff;

   // A press event is only ever raised for a key that is held.
   a_event_held : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_press_events & ~rsp_held_keys) == '0))
      else $error("press event on a key that is not held");

   // A full input register behind a stalled result must push back.
   a_backpressure : assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && out_valid_ff && rsp_stall) |-> req_stall)
      else $error("input register overrun while result is stalled");

   // A released key 0 leaves its counters cleared.
   a_release_clear : assert property (@(posedge clock) disable iff (reset)
      (advance && !key_down[0]) |=> (hold_ff[0] == '0 && phase_ff[0] == '0))
      else $error("released key kept its hold count");

   // A new result beat only appears when a frame has moved forward.
   a_result_source : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(advance))
      else $error("result beat without a frame behind it");

endmodule : key_autorepeat_scanner_unit

`default_nettype wire

// File: dv/kas_tb_pkg.sv
// Scoreboard for the key auto-repeat scanner bench: a per-key hold and repeat
// tracker that predicts every result beat and checks the beats the DUT sends.
// Depends on kas_pkg for the field widths and register indexes.
package kas_tb_pkg;
   import kas_pkg::*;

   // The index port is two bits wide, so two indexes select no register.
   localparam logic [CSR_IDX_BITS-1:0] REG_SPARE_2 = CSR_IDX_BITS'(2);
   localparam logic [CSR_IDX_BITS-1:0] REG_SPARE_3 = CSR_IDX_BITS'(3);

   localparam int KEY_COUNT    = 12;
   localparam int HOLD_BITS    = 16;
   localparam int REPORT_LIMIT = 10;

   localparam logic [STICK_BITS-1:0] DEAD_LOW  = STICK_BITS'(64);
   localparam logic [STICK_BITS-1:0] DEAD_HIGH = STICK_BITS'(191);

   localparam int FLAG_UP    = 0;
   localparam int FLAG_DOWN  = 1;
   localparam int FLAG_LEFT  = 2;
   localparam int FLAG_RIGHT = 3;

   typedef struct packed {
      logic [LEVEL_BITS-1:0] press_events;
      logic [LEVEL_BITS-1:0] held_keys;
      logic [DIR_BITS-1:0]   stick_dirs;
   } scan_result_type;

   class keyscan_scoreboard_type;
      logic [HOLD_BITS-1:0] hold_count [KEY_COUNT];
      logic [HOLD_BITS-1:0] repeat_phase [KEY_COUNT];
      logic [CFG_BITS-1:0]  repeat_delay;
      logic [CFG_BITS-1:0]  repeat_period;
      scan_result_type      expected_scans [$];
      int unsigned          mismatches;
      int unsigned          frames_taken;
      int unsigned          beats_checked;
      int unsigned          presses_seen;

      function new();
         foreach (hold_count[k]) begin
            hold_count[k]   = '0;
            repeat_phase[k] = '0;
         end
         repeat_delay  = CFG_BITS'(30);
         repeat_period = CFG_BITS'(5);
         mismatches    = 0;
         frames_taken  = 0;
         beats_checked = 0;
         presses_seen  = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] data);
         case (idx)
            REG_REPEAT_DELAY: begin
               repeat_delay = data;
            end
            REG_REPEAT_PERIOD: begin
               repeat_period = data;
            end
            default: begin
            end
         endcase
      endfunction

      function int unsigned pending();
         return expected_scans.size();
      endfunction

      // Advances every key by one frame and queues the result beat it yields.
      function void take_frame(logic [LEVEL_BITS-1:0] levels,
                               logic [STICK_BITS-1:0] sx, logic [STICK_BITS-1:0] sy);
         logic [CFG_BITS-1:0]  delay_eff;
         logic [CFG_BITS-1:0]  period_eff;
         logic [HOLD_BITS-1:0] prev;
         logic [HOLD_BITS-1:0] now;
         logic [HOLD_BITS:0]   step;
         logic                 fire;
         scan_result_type      res;
         int                   k;
         delay_eff  = (repeat_delay == '0) ? CFG_BITS'(1) : repeat_delay;
         period_eff = (repeat_period == '0) ? CFG_BITS'(1) : repeat_period;
         res = '0;
         for (k = 0; k < KEY_COUNT; k++) begin
            if (!levels[k]) begin
               hold_count[k]   = '0;
               repeat_phase[k] = '0;
            end else begin
               prev = hold_count[k];
               // The hold count sticks at its top value, so repeats never stop.
               now  = (prev == '1) ? prev : prev + 1'b1;
               fire = (now == HOLD_BITS'(1));
               hold_count[k] = now;
               res.held_keys[k] = 1'b1;
               if (now >= delay_eff) begin
                  if (prev < delay_eff) begin
                     repeat_phase[k] = '0;
                  end else begin
                     step = {1'b0, repeat_phase[k]} + 1'b1;
                     repeat_phase[k] = (step >= {1'b0, period_eff}) ? '0
                                                                    : step[HOLD_BITS-1:0];
                  end
                  if (repeat_phase[k] == '0) fire = 1'b1;
               end
               res.press_events[k] = fire;
            end
         end
         res.stick_dirs[FLAG_UP]    = (sy < DEAD_LOW);
         res.stick_dirs[FLAG_DOWN]  = (sy > DEAD_HIGH);
         res.stick_dirs[FLAG_LEFT]  = (sx < DEAD_LOW);
         res.stick_dirs[FLAG_RIGHT] = (sx > DEAD_HIGH);
         expected_scans.push_back(res);
         frames_taken++;
      endfunction

      function void compare_field(string name, logic [LEVEL_BITS-1:0] want,
                                  logic [LEVEL_BITS-1:0] got);
         if (want !== got) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("beat %0d %s: expected %h, got %h", beats_checked, name, want, got);
         end
      endfunction

      function void check_beat(scan_result_type got);
         scan_result_type want;
         beats_checked++;
         presses_seen += $countones(got.press_events);
         if (expected_scans.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("beat %0d arrived with no frame outstanding: press %h held %h dirs %h",
                        beats_checked, got.press_events, got.held_keys, got.stick_dirs);
            return;
         end
         want = expected_scans.pop_front();
         compare_field("press_events", want.press_events, got.press_events);
         compare_field("held_keys", want.held_keys, got.held_keys);
         compare_field("stick_dirs", LEVEL_BITS'(want.stick_dirs),
                       LEVEL_BITS'(got.stick_dirs));
      endfunction
   endclass

endpackage : kas_tb_pkg

// File: dv/tb_top.sv
// Top of the key auto-repeat scanner bench: clock, reset, frame sender, result
// receiver with random stalls, register writes and a watchdog.
// Depends on kas_pkg, kas_tb_pkg and key_autorepeat_scanner_unit.
module tb_top;
   import kas_pkg::*;
   import kas_tb_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int LONG_HOLD      = 200;
   localparam int PHASE_FRAMES   = 250;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic [LEVEL_BITS-1:0]   req_button_levels = '0;
   logic [STICK_BITS-1:0]   req_stick_x = '0;
   logic [STICK_BITS-1:0]   req_stick_y = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic [LEVEL_BITS-1:0]   rsp_press_events;
   logic [LEVEL_BITS-1:0]   rsp_held_keys;
   logic [DIR_BITS-1:0]     rsp_stick_dirs;
   logic                    csr_write_en = 1'b0;
   logic [CSR_IDX_BITS-1:0] csr_index = '0;
   logic [CFG_BITS-1:0]     csr_wdata = '0;

   keyscan_scoreboard_type sb;
   logic [LEVEL_BITS-1:0]  levels_now = '0;
   int unsigned            send_idle_pct = 0;
   int unsigned            stall_pct = 0;
   int unsigned            settings_used = 0;
   int unsigned            quiet_cycles = 0;

   key_autorepeat_scanner_unit uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_button_levels (req_button_levels),
      .req_stick_x       (req_stick_x),
      .req_stick_y       (req_stick_y),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_press_events  (rsp_press_events),
      .rsp_held_keys     (rsp_held_keys),
      .rsp_stick_dirs    (rsp_stick_dirs),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always #1 clock = ~clock;

   // Receiver: random stalls, result checking and the watchdog.
   always @(posedge clock) begin
      rsp_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
      if (!reset) begin
         if (rsp_valid && !rsp_stall)
            sb.check_beat({rsp_press_events, rsp_held_keys, rsp_stick_dirs});
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no beat moved in %0d cycles.", WATCHDOG_LIMIT);
            $display("FAILED: results differ");
            $finish;
         end
      end
   end

   // Presents one frame and returns at the edge that accepts it.
   task automatic send_frame(input logic [LEVEL_BITS-1:0] levels,
                             input logic [STICK_BITS-1:0] sx, input logic [STICK_BITS-1:0] sy);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_button_levels <= levels;
      req_stick_x       <= sx;
      req_stick_y       <= sy;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.take_frame(levels, sx, sy);
   endtask

   // Mostly long holds with each key toggling now and then on its own, so repeats
   // get reached; now and then a fully random mask replaces every key's level.
   task automatic send_random_frame();
      int k;
      if ($urandom_range(99) < 5) begin
         levels_now = LEVEL_BITS'($urandom_range(4095));
      end else begin
         for (k = 0; k < KEY_COUNT; k++)
            if ($urandom_range(24) == 0) levels_now[k] = ~levels_now[k];
      end
      send_frame(levels_now, STICK_BITS'($urandom_range(255)), STICK_BITS'($urandom_range(255)));
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_BITS-1:0] idx, input logic [CFG_BITS-1:0] data);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      @(posedge clock);
      sb.write_reg(idx, data);
   endtask

   // Registers change only with no frame in flight. Held keys keep their
   // counts across the change, so a lowered delay lands mid-hold.
   task automatic apply_settings(input logic [CFG_BITS-1:0] delay_val,
                                 input logic [CFG_BITS-1:0] period_val);
      wait_drained();
      write_csr(REG_SPARE_2, CFG_BITS'($urandom_range(65535)));
      write_csr(REG_REPEAT_DELAY, delay_val);
      write_csr(REG_SPARE_3, CFG_BITS'($urandom_range(65535)));
      write_csr(REG_REPEAT_PERIOD, period_val);
      csr_write_en <= 1'b0;
      settings_used++;
   endtask

   task automatic run_phase(input int unsigned frames, input int unsigned idle_pct,
                            input int unsigned stall_chance);
      send_idle_pct = idle_pct;
      stall_pct     = stall_chance;
      repeat (frames) begin
         send_random_frame();
         // Occasionally let the pipeline run empty before the next frame.
         if ($urandom_range(199) == 0) wait_drained();
      end
   endtask

   initial begin
      int k;
      sb = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Field extremes and stick thresholds under the reset settings.
      send_frame(12'h000, 8'd127, 8'd127);
      send_frame(12'hFFF, 8'd0, 8'd0);
      send_frame(12'hFFF, 8'd255, 8'd255);
      send_frame(12'h000, 8'd63, 8'd64);
      send_frame(12'h001, 8'd64, 8'd63);
      send_frame(12'h800, 8'd191, 8'd192);
      send_frame(12'h801, 8'd192, 8'd191);
      send_frame(12'hAAA, 8'd128, 8'd0);
      send_frame(12'h555, 8'd0, 8'd128);
      send_frame(12'h000, 8'd255, 8'd255);
      send_frame(12'hFFF, 8'd127, 8'd127);
      send_frame(12'h7FF, 8'd63, 8'd191);
      send_frame(12'hFFF, 8'd192, 8'd64);
      send_frame(12'h000, 8'd127, 8'd127);

      run_phase(PHASE_FRAMES, 0, 0);
      apply_settings(CFG_BITS'(0), CFG_BITS'(0));
      run_phase(PHASE_FRAMES, 62, 0);
      apply_settings(CFG_BITS'(1), CFG_BITS'(1));
      run_phase(PHASE_FRAMES, 0, 62);
      apply_settings(CFG_BITS'(4), CFG_BITS'(3));
      run_phase(PHASE_FRAMES, 35, 35);
      apply_settings(CFG_BITS'(65535), CFG_BITS'(65535));
      run_phase(PHASE_FRAMES, 0, 0);
      apply_settings(CFG_BITS'(3), CFG_BITS'(2));
      run_phase(PHASE_FRAMES, 62, 0);
      apply_settings(CFG_BITS'($urandom_range(40, 1)), CFG_BITS'($urandom_range(12, 1)));
      run_phase(PHASE_FRAMES, 0, 62);

      // Hold every key well past the delay so repeats are running, then cut
      // the delay below the count reached and shorten the period.
      apply_settings(CFG_BITS'(40), CFG_BITS'(7));
      send_idle_pct = 0;
      stall_pct     = 0;
      for (k = 0; k < LONG_HOLD; k++)
         send_frame('1, STICK_BITS'($urandom_range(255)), STICK_BITS'($urandom_range(255)));
      apply_settings(CFG_BITS'(2), CFG_BITS'(4));
      send_idle_pct = 35;
      stall_pct     = 35;
      repeat (60)
         send_frame('1, STICK_BITS'($urandom_range(255)), STICK_BITS'($urandom_range(255)));

      wait_drained();
      repeat (8) @(posedge clock);
      $display("Run covered %0d frames under %0d register settings plus reset defaults,",
               sb.frames_taken, settings_used);
      $display("including a %0d-frame hold; %0d result beats carried %0d press events.",
               LONG_HOLD, sb.beats_checked, sb.presses_seen);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("%0d mismatches, %0d results never arrived.", sb.mismatches, sb.pending());
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule : tb_top

// File: files.f
hw/rtl/kas_pkg.sv
hw/rtl/key_autorepeat_scanner_unit.sv
dv/kas_tb_pkg.sv
dv/tb_top.sv
